>>> sv/pixel_brightness_ordered_dither_core_defines.svh
// Assertion helpers shared by the dither core.
`ifndef PIXEL_BRIGHTNESS_ORDERED_DITHER_CORE_DEFINES_SVH
`define PIXEL_BRIGHTNESS_ORDERED_DITHER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PBOD_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pbod check failed");

// next-cycle implication, disabled while reset is asserted
`define PBOD_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pbod check failed");

`endif

>>> sv/pbod_pkg.sv
package pbod_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned NUM_LANES      = 3;
  localparam int unsigned PIPE_DEPTH     = 4;

  localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
  localparam logic [1:0] REG_DITHER_EN  = 2'd1;
  localparam logic [1:0] REG_MONO_EN    = 2'd2;

  localparam logic [8:0]  BRIGHT_RST   = 9'd0;
  localparam logic [16:0] MONO_THRESH  = 17'd45824;  // 179 * 256

  typedef struct packed {
    logic [7:0] adj;    // brightness-adjusted channel
    logic [7:0] mask;   // position hash for this channel
    logic [7:0] level;  // 7-level colour dither result
  } lane_res_t;

  // level index 0..6 from v = floor(6*v/255)
  function automatic logic [2:0] level_code(input logic [8:0] v);
    logic [2:0] q;
    q = 3'd0;
    if (v >= 9'd43)  q = 3'd1;
    if (v >= 9'd85)  q = 3'd2;
    if (v >= 9'd128) q = 3'd3;
    if (v >= 9'd170) q = 3'd4;
    if (v >= 9'd213) q = 3'd5;
    if (v >= 9'd255) q = 3'd6;
    return q;
  endfunction

  // floor(255*q/6)
  function automatic logic [7:0] level_value(input logic [2:0] q);
    logic [7:0] r;
    unique case (q)
      3'd0:    r = 8'd0;
      3'd1:    r = 8'd42;
      3'd2:    r = 8'd85;
      3'd3:    r = 8'd127;
      3'd4:    r = 8'd170;
      3'd5:    r = 8'd212;
      3'd6:    r = 8'd255;
      default: r = 8'd255;
    endcase
    return r;
  endfunction

endpackage

>>> sv/pbod_lane.sv
module pbod_lane #(
  parameter int unsigned COORD_BITS = pbod_pkg::COORD_BITS_DEF,
  parameter int unsigned CHAN       = 0
) (
  input  logic                  clk_i,
  input  logic [COORD_BITS-1:0] px_i,
  input  logic [COORD_BITS-1:0] py_i,
  input  logic [7:0]            chan_i,
  input  logic [7:0]            bright_i,
  output pbod_pkg::lane_res_t   res_o
);
  import pbod_pkg::*;

  localparam logic [7:0] CHAN_OFS = 8'((CHAN * 67) % 256);

  logic [7:0]  xh, yh;
  logic [15:0] yprod;
  logic [7:0]  sum_d, sum_q;
  logic [7:0]  adj1_d, adj1_q, adj2_q;
  logic [15:0] mprod;
  logic [7:0]  mask_d, mask_q;
  logic [8:0]  m3;
  logic [16:0] tprod;
  logic [5:0]  t;
  logic [8:0]  vsum, v;
  lane_res_t   res_d, res_q;

  // stage 1: brightness and hash sum (mod 256 is all that matters)
  always_comb begin
    xh     = 8'(px_i >> 1);
    yh     = 8'(py_i >> 1);
    yprod  = yh * 8'd236;
    sum_d  = xh + CHAN_OFS + yprod[7:0];
    adj1_d = chan_i + bright_i;
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    adj1_q <= adj1_d;
  end

  // stage 2: hash scramble
  always_comb begin
    mprod  = sum_q * 8'd119;
    mask_d = mprod[7:0];
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    adj2_q <= adj1_q;
  end

  // stage 3: v = max(0, adj + floor((m+3)/6) - 1), then 7-level quantize
  always_comb begin
    m3    = {1'b0, mask_q} + 9'd3;
    tprod = m3 * 8'd171;          // x*171>>10 == x/6 for x < 259
    t     = tprod[15:10];
    vsum  = {1'b0, adj2_q} + {3'b000, t};
    v     = (vsum == 9'd0) ? 9'd0 : vsum - 9'd1;
    res_d.adj   = adj2_q;
    res_d.mask  = mask_q;
    res_d.level = level_value(level_code(v));
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> sv/pbod_merge.sv
module pbod_merge (
  input  logic                clk_i,
  input  pbod_pkg::lane_res_t lanes_i [pbod_pkg::NUM_LANES],
  input  logic                dith_i,
  input  logic                mono_i,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o
);
  import pbod_pkg::*;

  logic [14:0] mprod;
  logic [16:0] score;
  logic [7:0]  lit;
  logic [7:0]  red_d, green_d, blue_d;
  logic [7:0]  red_q, green_q, blue_q;

  // mono threshold uses the red-lane hash against adjusted green
  always_comb begin
    mprod = lanes_i[0].mask * 7'd100;
    score = {1'b0, lanes_i[1].adj, 8'h00} + {2'b00, mprod};
    lit   = (score >= MONO_THRESH) ? 8'hff : 8'h00;
    priority if (dith_i && mono_i) begin
      red_d   = lit;
      green_d = lit;
      blue_d  = lit;
    end else if (dith_i) begin
      red_d   = lanes_i[0].level;
      green_d = lanes_i[1].level;
      blue_d  = lanes_i[2].level;
    end else begin
      red_d   = lanes_i[0].adj;
      green_d = lanes_i[1].adj;
      blue_d  = lanes_i[2].adj;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

>>> sv/pixel_brightness_ordered_dither_core.sv
// channel   direction  handshake              payload
// pixel     in         start_i / busy_o       pixel_x_i, pixel_y_i, red/green/blue_in_i
// result    out        valid_o (strobe)       red_out_o, green_out_o, blue_out_o
// config    in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One pixel per clock; each result is registered in the 3 lane stages
// and then in the merge register. busy_o never rises.
// Reset sets config defaults (dither on), clears valid pipeline; data regs not reset.
// The result strobe lasts one cycle and cannot be held off.
`include "pixel_brightness_ordered_dither_core_defines.svh"

module pixel_brightness_ordered_dither_core #(
  parameter int unsigned COORD_BITS = pbod_pkg::COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [COORD_BITS-1:0] pixel_x_i,
  input  logic [COORD_BITS-1:0] pixel_y_i,
  input  logic [7:0]            red_in_i,
  input  logic [7:0]            green_in_i,
  input  logic [7:0]            blue_in_i,
  output logic                  valid_o,
  output logic [7:0]            red_out_o,
  output logic [7:0]            green_out_o,
  output logic [7:0]            blue_out_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [8:0]            cfg_data_i
);
  import pbod_pkg::*;

  logic [8:0]            bright_q;
  logic                  dith_q, mono_q;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic                  accept;
  logic [7:0]            chans [NUM_LANES];
  lane_res_t             lane_res [NUM_LANES];

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= BRIGHT_RST;
      dith_q   <= 1'b1;
      mono_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_BRIGHTNESS: bright_q <= cfg_data_i;
        REG_DITHER_EN:  dith_q   <= cfg_data_i[0];
        REG_MONO_EN:    mono_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], accept};
    end
  end

  assign chans[0] = red_in_i;
  assign chans[1] = green_in_i;
  assign chans[2] = blue_in_i;

  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    pbod_lane #(
      .COORD_BITS (COORD_BITS),
      .CHAN       (c)
    ) u_lane (
      .clk_i    (clk_i),
      .px_i     (pixel_x_i),
      .py_i     (pixel_y_i),
      .chan_i   (chans[c]),
      .bright_i (bright_q[7:0]),
      .res_o    (lane_res[c])
    );
  end

  pbod_merge u_merge (
    .clk_i   (clk_i),
    .lanes_i (lane_res),
    .dith_i  (dith_q),
    .mono_i  (mono_q),
    .red_o   (red_out_o),
    .green_o (green_out_o),
    .blue_o  (blue_out_o)
  );

  assign valid_o = vld_q[PIPE_DEPTH-1];

  `PBOD_ASSERT_IMP(a_result_follows, clk_i, rst_ni, accept, ##4 valid_o)
  `PBOD_ASSERT_IMP(a_no_spurious, clk_i, rst_ni, valid_o, $past(accept, 4))
  `PBOD_ASSERT_NXT(a_mono_gray, clk_i, rst_ni, vld_q[PIPE_DEPTH-2] && dith_q && mono_q,
    (red_out_o == green_out_o) && (green_out_o == blue_out_o))

endmodule

>>> tb/tb_pixel_brightness_ordered_dither_core.sv
module tb_pixel_brightness_ordered_dither_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pbod_pkg::*;

  localparam int unsigned CB         = COORD_BITS_DEF;
  localparam logic [1:0]  REG_SPARE  = 2'd3;  // no register behind this index
  localparam int unsigned IDLE_PCT   = 17;
  localparam int unsigned STALL_MAX  = 2000;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned RAND_ITEMS  = 92;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [7:0]    r;
    logic [7:0]    g;
    logic [7:0]    b;
  } pixel_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          start_i     = 1'b0;
  logic [CB-1:0] pixel_x_i   = '0;
  logic [CB-1:0] pixel_y_i   = '0;
  logic [7:0]    red_in_i    = '0;
  logic [7:0]    green_in_i  = '0;
  logic [7:0]    blue_in_i   = '0;
  logic          cfg_valid_i = 1'b0;
  logic [1:0]    cfg_index_i = '0;
  logic [8:0]    cfg_data_i  = '0;
  logic          busy_o;
  logic          valid_o;
  logic [7:0]    red_out_o;
  logic [7:0]    green_out_o;
  logic [7:0]    blue_out_o;
  logic          cfg_ready_o;

  // shadow copy of the config registers
  logic [8:0] brightness_r = BRIGHT_RST;
  logic       dither_r     = 1'b1;
  logic       mono_r       = 1'b0;

  pixel_t      pixel_q[$];
  rgb_t        predicted_q[$];
  int unsigned pixels_total = 0;
  int unsigned pixels_done  = 0;
  int unsigned fail_cnt     = 0;
  int unsigned stall_cnt    = 0;
  bit          steady       = 1'b0;

  pixel_brightness_ordered_dither_core #(
    .COORD_BITS(CB)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .red_in_i   (red_in_i),
    .green_in_i (green_in_i),
    .blue_in_i  (blue_in_i),
    .valid_o    (valid_o),
    .red_out_o  (red_out_o),
    .green_out_o(green_out_o),
    .blue_out_o (blue_out_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // 2x2 blocks share one mask value
  function automatic int unsigned pos_mask(input logic [CB-1:0] x, input logic [CB-1:0] y,
                                           input int unsigned c);
    int unsigned s;
    s = int'(x >> 1) + c * 67 + int'(y >> 1) * 236;
    return (s * 119) & 255;
  endfunction

  function automatic rgb_t dither_pixel(input pixel_t p);
    logic [7:0]  ch[3];
    int unsigned m, num, v, q;
    logic [7:0]  lit;
    ch[0] = p.r + brightness_r[7:0];
    ch[1] = p.g + brightness_r[7:0];
    ch[2] = p.b + brightness_r[7:0];
    if (dither_r) begin
      if (mono_r) begin
        m   = pos_mask(p.x, p.y, 0);
        lit = (256 * int'(ch[1]) + 100 * m >= int'(MONO_THRESH)) ? 8'hFF : 8'h00;
        ch[0] = lit;
        ch[1] = lit;
        ch[2] = lit;
      end else begin
        for (int c = 0; c < 3; c++) begin
          m   = pos_mask(p.x, p.y, c);
          num = 6 * int'(ch[c]) + m;
          v   = (num >= 3) ? (num - 3) / 6 : 0;
          q   = (v * 6) / 255;
          ch[c] = 8'((q * 255) / 6);
        end
      end
    end
    return '{r: ch[0], g: ch[1], b: ch[2]};
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(15))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [8:0] rand_brightness();
    case ($urandom_range(7))
      0:       return 9'h000;
      1:       return 9'h0FF;  // +255
      2:       return 9'h101;  // -255
      3:       return 9'h100;  // -256, same as zero
      4:       return 9'h1FF;  // -1
      default: return 9'($urandom_range(511));
    endcase
  endfunction

  task automatic add_pixel(input int unsigned x, input int unsigned y,
                           input int unsigned r, input int unsigned g, input int unsigned b);
    pixel_q.push_back('{x: CB'(x), y: CB'(y), r: 8'(r), g: 8'(g), b: 8'(b)});
    pixels_total++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
    @(posedge clk_i);
    while (!steady && $urandom_range(99) < IDLE_PCT) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_BRIGHTNESS: brightness_r = data;
      REG_DITHER_EN:  dither_r     = data[0];
      REG_MONO_EN:    mono_r       = data[0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  // sender stays quiet until every predicted result is back
  task automatic drain();
    while (pixels_done != pixels_total || predicted_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset config: colour dither, no offset
    add_pixel(0, 0, 0, 0, 0);
    add_pixel(4095, 4095, 255, 255, 255);
    add_pixel(1, 1, 1, 2, 3);
    add_pixel(2, 0, 254, 128, 127);
    add_pixel(0, 4095, 43, 42, 85);
    add_pixel(4094, 1, 212, 213, 170);
    add_pixel(2730, 1365, 0, 255, 1);
    add_pixel(1365, 2730, 255, 0, 254);
    drain();

    // mono threshold, offset of -256 is a no-op, spare index ignored
    write_reg(REG_SPARE, 9'h1A5);
    write_reg(REG_BRIGHTNESS, 9'h100);
    write_reg(REG_MONO_EN, 9'h001);
    add_pixel(0, 0, 0, 179, 0);
    add_pixel(1, 1, 255, 178, 255);
    add_pixel(4095, 0, 0, 255, 0);
    add_pixel(0, 4095, 17, 0, 99);
    add_pixel(3000, 777, 200, 140, 60);
    drain();

    // dither off: mono setting must have no effect, +255 wraps
    write_reg(REG_BRIGHTNESS, 9'h0FF);
    write_reg(REG_DITHER_EN, 9'h1FE);
    add_pixel(5, 9, 0, 1, 255);
    add_pixel(4095, 4095, 128, 200, 17);
    add_pixel(0, 0, 255, 0, 64);
    drain();

    write_reg(REG_BRIGHTNESS, 9'h101);
    write_reg(REG_DITHER_EN, 9'h001);
    write_reg(REG_MONO_EN, 9'h100);
    add_pixel(7, 3, 0, 255, 1);
    add_pixel(4095, 2048, 254, 2, 128);
    add_pixel(2048, 4095, 255, 255, 0);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      steady = (ph == 1);
      if ($urandom_range(3) == 0) write_reg(REG_SPARE, 9'($urandom_range(511)));
      write_reg(REG_BRIGHTNESS, rand_brightness());
      write_reg(REG_DITHER_EN, 9'($urandom_range(511)) | 9'(ph != 2));
      write_reg(REG_MONO_EN, {8'($urandom_range(255)), 1'(ph % 2)});
      for (int i = 0; i < RAND_ITEMS; i++)
        add_pixel($urandom_range(4095), $urandom_range(4095), rand_chan(), rand_chan(),
                  rand_chan());
      drain();
    end
    steady = 1'b0;

    if (fail_cnt == 0 && predicted_q.size() == 0) begin
      $display("tb_pixel_brightness_ordered_dither_core: PASS");
    end else begin
      $display("tb_pixel_brightness_ordered_dither_core: FAIL");
    end
    $finish;
  end

  // pixel driver
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t nxt;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        predicted_q.push_back(dither_pixel('{x: pixel_x_i, y: pixel_y_i, r: red_in_i,
                                             g: green_in_i, b: blue_in_i}));
        pixels_done++;
      end
      if (start_i && busy_o) begin
        // hold the pending transfer
      end else if (pixel_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = pixel_q.pop_front();
        pixel_x_i  <= nxt.x;
        pixel_y_i  <= nxt.y;
        red_in_i   <= nxt.r;
        green_in_i <= nxt.g;
        blue_in_i  <= nxt.b;
        start_i    <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni && valid_o) begin
      if (predicted_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result r=%0d g=%0d b=%0d", red_out_o, green_out_o, blue_out_o);
      end else begin
        want = predicted_q.pop_front();
        if (red_out_o !== want.r || green_out_o !== want.g || blue_out_o !== want.b) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.r, want.g, want.b, red_out_o, green_out_o, blue_out_o);
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_MAX) begin
      $display("tb_pixel_brightness_ordered_dither_core: FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

endmodule
